// ===== rtl/core/sed_pkg.sv =====
package sed_pkg;

  // Width of the status code carried with every result.
  localparam int unsigned STATUS_W = 2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture operands and their magnitudes
    logic step;     // one non-restoring iteration
    logic restore;  // make the partial remainder nonnegative
    logic finish;   // sign and Euclidean fix-up into the output register
  } sed_cmd_t;

endpackage

// ===== rtl/core/sed_ctrl.sv =====
module sed_ctrl #(
  parameter int unsigned WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sed_pkg::sed_cmd_t cmd
);

  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_RESTORE,
    ST_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  // The result may enter the output register once it is empty or being taken.
  assign fire      = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  assign cmd.load    = accept;
  assign cmd.step    = (state_r == ST_RUN);
  assign cmd.restore = (state_r == ST_RESTORE);
  assign cmd.finish  = fire;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_RESTORE;
        end
      end
      ST_RESTORE: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/sed_datapath.sv =====
module sed_datapath #(
  parameter int unsigned WIDTH = 16
) (
  input  logic                           clk,
  input  sed_pkg::sed_cmd_t              cmd,
  input  logic [WIDTH-1:0]               dividend,
  input  logic [WIDTH-1:0]               divisor,
  output logic [WIDTH-1:0]               quotient,
  output logic [WIDTH-2:0]               remainder,
  output logic [sed_pkg::STATUS_W-1:0]   status
);

  logic             an_r, bn_r;
  logic [WIDTH-1:0] mb_r;
  logic [WIDTH-1:0] q_r;
  logic [WIDTH:0]   rem_r;      // two's-complement partial remainder
  logic [WIDTH-1:0] quot_r;
  logic [WIDTH-2:0] remd_r;
  logic [sed_pkg::STATUS_W-1:0] status_r;

  logic [WIDTH-1:0] ma, mb;
  logic [WIDTH:0]   shifted, step_sum;
  logic [WIDTH-1:0] rm;
  logic             inc, neg, overflow, div_zero;
  logic [WIDTH-1:0] q_sel, q_fix, r_diff;

  assign ma = dividend[WIDTH-1] ? (~dividend + WIDTH'(1)) : dividend;
  assign mb = divisor[WIDTH-1]  ? (~divisor + WIDTH'(1))  : divisor;

  // Subtract while the partial remainder is nonnegative, add back otherwise.
  assign shifted  = {rem_r[WIDTH-1:0], q_r[WIDTH-1]};
  assign step_sum = rem_r[WIDTH] ? (shifted + {1'b0, mb_r}) : (shifted - {1'b0, mb_r});

  // Fix-up: a negative dividend with a nonzero remainder rounds the
  // magnitude up; negating q+1 is simply ~q.
  assign rm       = rem_r[WIDTH-1:0];
  assign inc      = an_r && (rm != '0);
  assign neg      = an_r ^ bn_r;
  assign q_sel    = neg ? ~q_r : q_r;
  assign q_fix    = q_sel + WIDTH'(neg ? !inc : inc);
  assign r_diff   = mb_r - rm;
  assign div_zero = (mb_r == '0);
  // Only 2^(WIDTH-1) with a nonnegative sign cannot be represented.
  assign overflow = !neg && q_r[WIDTH-1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an_r  <= dividend[WIDTH-1];
      bn_r  <= divisor[WIDTH-1];
      mb_r  <= mb;
      q_r   <= ma;
      rem_r <= '0;
    end else if (cmd.step) begin
      rem_r <= step_sum;
      q_r   <= {q_r[WIDTH-2:0], ~step_sum[WIDTH]};
    end else if (cmd.restore) begin
      if (rem_r[WIDTH]) begin
        rem_r <= rem_r + {1'b0, mb_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (div_zero) begin
        quot_r   <= '0;
        remd_r   <= '0;
        status_r <= sed_pkg::STATUS_DIV_ZERO;
      end else if (overflow) begin
        quot_r   <= '0;
        remd_r   <= '0;
        status_r <= sed_pkg::STATUS_OVERFLOW;
      end else begin
        quot_r   <= q_fix;
        remd_r   <= inc ? r_diff[WIDTH-2:0] : rm[WIDTH-2:0];
        status_r <= sed_pkg::STATUS_OK;
      end
    end
  end

  assign quotient  = quot_r;
  assign remainder = remd_r;
  assign status    = status_r;

endmodule

// ===== rtl/core/signed_euclidean_divider_unit.sv =====
// Signed Euclidean divider. Each input item carries a WIDTH-bit two's-complement
// dividend and divisor; each result item carries the quotient and a remainder
// that is never negative and always below the divisor's magnitude, so that
// dividend = quotient * divisor + remainder holds. The magnitudes are divided
// by a non-restoring shift-and-add/subtract loop that produces one quotient bit
// per cycle, followed by a restore step that makes the partial remainder
// nonnegative and a finish step that applies the sign and Euclidean correction.
// The WIDTH iterations share one add/subtract unit; the block works on one
// item at a time and in_tready is high only while it waits for a new item.
// The result sits in an output register, so a new item is taken even while
// the previous result waits; a finished result waits in the datapath only if
// the earlier one is still unread. A zero divisor yields status 1 and a
// quotient that does not fit (most negative dividend divided by -1) yields
// status 2; in both cases the quotient and remainder are zero.
module signed_euclidean_divider_unit #(
  parameter int unsigned WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0 up: dividend (WIDTH), divisor (WIDTH), zero padding.
  input  logic [((2*WIDTH+7)/8)*8-1:0]         in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0 up: quotient (WIDTH), remainder (WIDTH-1), zero padding.
  output logic [((2*WIDTH+6)/8)*8-1:0]         out_tdata,
  // Fields from bit 0 up: status (0 ok, 1 divide by zero, 2 overflow).
  output logic [sed_pkg::STATUS_W-1:0]         out_tuser
);

  localparam int unsigned OUT_TDATA_W = ((2*WIDTH+6)/8)*8;
  localparam int unsigned LATENCY     = WIDTH + 3;

  sed_pkg::sed_cmd_t            cmd;
  logic [WIDTH-1:0]             quotient;
  logic [WIDTH-2:0]             remainder;
  logic [sed_pkg::STATUS_W-1:0] status;

  sed_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  sed_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .dividend  (in_tdata[WIDTH-1:0]),
    .divisor   (in_tdata[2*WIDTH-1:WIDTH]),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (status)
  );

  // The size cast fills the padding bits above the remainder with zeros.
  assign out_tdata = OUT_TDATA_W'({remainder, quotient});
  assign out_tuser = status;

  // Once an item is taken, no other item is taken in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // An error result carries zero quotient and remainder.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != sed_pkg::STATUS_OK) |-> (out_tdata == '0))
    else $error("error result with nonzero payload");

  // With the output register empty, a taken item's result is never stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid) |-> ##LATENCY out_tvalid)
    else $error("result not delivered after the expected latency");

  // A status code outside the defined set never leaves the block.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == sed_pkg::STATUS_OK ||
                    out_tuser == sed_pkg::STATUS_DIV_ZERO ||
                    out_tuser == sed_pkg::STATUS_OVERFLOW))
    else $error("undefined status code");

endmodule
